FILE: rtl/lbpc_pkg.sv
// Shared types and constants for the LRU buffer pool controller.
package lbpc_pkg;
    localparam int SLOTS       = 16;
    localparam int SLOT_W      = 4;
    localparam int OFF_W       = 12;
    localparam int TAG_W       = 20;
    localparam int FILE_W      = 8;
    localparam int ADDR_W      = 32;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_READ  = 3'd0;
    localparam t_opcode OP_WRITE = 3'd1;
    localparam t_opcode OP_PIN   = 3'd2;
    localparam t_opcode OP_UNPIN = 3'd3;
    localparam t_opcode OP_INVAL = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_HIT    = 2'd0;
    localparam t_status ST_MISS   = 2'd1;
    localparam t_status ST_PINNED = 2'd2;
    localparam t_status ST_MAINT  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_SCAN, S_MOVE, S_INVAL, S_DONE
    } t_state;

    typedef logic [SLOT_W-1:0] t_slot;
endpackage

FILE: rtl/lru_buffer_pool_controller.sv
// Top level of the LRU buffer pool controller with pin bits and write-back.
// One request at a time. A read or write walks the 16 slots one per cycle
// through a single tag comparator; a miss then scans from the LRU end, one
// slot per cycle, moving pinned slots to the MRU end and reporting the
// all-pinned error once all 16 slots have been passed pinned. A hit, miss or
// all-pinned result is built in a staging register and moves to the output
// register in the final state; other results are written there directly.
// While an earlier result is still waiting there, the request holds in that
// final state.
module lru_buffer_pool_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_opcode,
    input  logic [7:0]                    i_file_id,
    input  logic [31:0]                   i_byte_address,
    input  logic [3:0]                    i_slot_select,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [3:0]                    o_slot,
    output logic [11:0]                   o_block_offset,
    output logic [19:0]                   o_fetch_tag,
    output logic                          o_writeback_needed,
    output logic [7:0]                    o_writeback_file,
    output logic [19:0]                   o_writeback_tag
);
    import lbpc_pkg::*;

    t_state r_state, n_state;
    t_opcode r_op;
    logic [FILE_W-1:0] r_file;
    logic [TAG_W-1:0] r_tag;
    logic [OFF_W-1:0] r_off;
    t_slot r_sel;
    logic [SLOT_W:0] r_cnt, n_cnt;

    logic [SLOTS-1:0] r_vld, r_dirty, r_pin;
    logic [FILE_W-1:0] r_sfile [SLOTS];
    logic [TAG_W-1:0]  r_stag [SLOTS];

    logic r_ovalid;
    t_status r_ostatus;
    t_slot r_oslot;
    logic [OFF_W-1:0] r_ooff;
    logic [TAG_W-1:0] r_ofetch, r_owbtag;
    logic r_owb;
    logic [FILE_W-1:0] r_owbfile;

    t_status r_rstatus;
    t_slot r_rslot;
    logic [OFF_W-1:0] r_roff;
    logic [TAG_W-1:0] r_rfetch, r_rwbtag;
    logic r_rwb;
    logic [FILE_W-1:0] r_rwbfile;

    logic w_move;
    t_slot w_mslot, w_lru, w_idx;
    logic w_match;

    lbpc_order u_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (w_move),
        .i_slot  (w_mslot),
        .o_lru   (w_lru)
    );

    assign w_idx = r_cnt[SLOT_W-1:0];
    assign w_match = r_vld[w_idx] && r_sfile[w_idx] == r_file && r_stag[w_idx] == r_tag;

    logic w_accept, w_free;
    assign w_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
    end

    // result actions computed in the combinational block
    logic w_hit, w_fill, w_err, w_maint;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        w_move = 1'b0;
        w_mslot = w_lru;
        w_hit = 1'b0;
        w_fill = 1'b0;
        w_err = 1'b0;
        w_maint = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    if (i_opcode == OP_READ || i_opcode == OP_WRITE) begin
                        n_state = S_LOOKUP;
                    end else if (i_opcode == OP_INVAL) begin
                        n_state = S_INVAL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOOKUP: begin
                if (w_match) begin
                    w_move = 1'b1;
                    w_mslot = w_idx;
                    n_state = S_MOVE;
                end else if (r_cnt == (SLOT_W+1)'(SLOTS - 1)) begin
                    n_cnt = '0;
                    n_state = S_SCAN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MOVE: begin
                w_hit = 1'b1;
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (r_cnt == (SLOT_W+1)'(SLOTS)) begin
                    w_err = 1'b1;
                    n_state = S_DONE;
                end else if (r_pin[w_lru]) begin
                    w_move = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    w_move = 1'b1;
                    w_fill = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_INVAL: begin
                if (r_cnt == (SLOT_W+1)'(SLOTS - 1)) begin
                    n_state = S_DONE;
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_DONE: begin
                w_maint = 1'b1;
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // S_DONE with the staging register loaded by hit/fill/err: only publish
    logic r_loaded;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_opcode;
            r_file <= i_file_id;
            r_tag  <= i_byte_address[ADDR_W-1:OFF_W];
            r_off  <= i_byte_address[OFF_W-1:0];
            r_sel  <= i_slot_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_dirty <= '0;
            r_pin   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_sfile[i] <= '0;
                r_stag[i]  <= '0;
            end
        end else begin
            if (w_hit && r_op == OP_WRITE) begin
                r_dirty[r_rslot] <= 1'b1;
            end
            if (w_fill) begin
                r_vld[w_lru]   <= 1'b1;
                r_dirty[w_lru] <= (r_op == OP_WRITE);
                r_sfile[w_lru] <= r_file;
                r_stag[w_lru]  <= r_tag;
            end
            if (r_state == S_INVAL && r_vld[w_idx] && r_sfile[w_idx] == r_file) begin
                r_vld[w_idx]   <= 1'b0;
                r_dirty[w_idx] <= 1'b0;
                r_pin[w_idx]   <= 1'b0;
                r_sfile[w_idx] <= '0;
                r_stag[w_idx]  <= '0;
            end
            if (r_state == S_DONE && !r_loaded && w_free &&
                (r_op == OP_PIN || r_op == OP_UNPIN)) begin
                r_pin[r_sel] <= (r_op == OP_PIN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_loaded <= 1'b0;
        end else begin
            if (r_state == S_LOOKUP && w_match) begin
                r_rslot <= w_idx;
            end
            if (w_hit) begin
                r_loaded  <= 1'b1;
                r_rstatus <= ST_HIT;
                r_roff    <= r_off;
                r_rfetch  <= '0;
                r_rwb     <= 1'b0;
                r_rwbfile <= '0;
                r_rwbtag  <= '0;
            end
            if (w_fill) begin
                r_loaded  <= 1'b1;
                r_rstatus <= ST_MISS;
                r_rslot   <= w_lru;
                r_roff    <= r_off;
                r_rfetch  <= r_tag;
                r_rwb     <= r_vld[w_lru] && r_dirty[w_lru];
                r_rwbfile <= (r_vld[w_lru] && r_dirty[w_lru]) ? r_sfile[w_lru] : '0;
                r_rwbtag  <= (r_vld[w_lru] && r_dirty[w_lru]) ? r_stag[w_lru] : '0;
            end
            if (w_err) begin
                r_loaded  <= 1'b1;
                r_rstatus <= ST_PINNED;
                r_rslot   <= '0;
                r_roff    <= '0;
                r_rfetch  <= '0;
                r_rwb     <= 1'b0;
                r_rwbfile <= '0;
                r_rwbtag  <= '0;
            end
            if (w_maint && w_free) begin
                r_ovalid <= 1'b1;
                r_loaded <= 1'b0;
                if (r_loaded) begin
                    r_ostatus <= r_rstatus;
                    r_oslot   <= r_rslot;
                    r_ooff    <= r_roff;
                    r_ofetch  <= r_rfetch;
                    r_owb     <= r_rwb;
                    r_owbfile <= r_rwbfile;
                    r_owbtag  <= r_rwbtag;
                end else begin
                    r_ostatus <= ST_MAINT;
                    r_oslot   <= (r_op == OP_PIN || r_op == OP_UNPIN) ? r_sel : '0;
                    r_ooff    <= '0;
                    r_ofetch  <= '0;
                    r_owb     <= 1'b0;
                    r_owbfile <= '0;
                    r_owbtag  <= '0;
                end
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_ovalid;
    assign o_status           = r_ostatus;
    assign o_slot             = r_oslot;
    assign o_block_offset     = r_ooff;
    assign o_fetch_tag        = r_ofetch;
    assign o_writeback_needed = r_owb;
    assign o_writeback_file   = r_owbfile;
    assign o_writeback_tag    = r_owbtag;

    property p_one_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_accept |=> !o_ready;
    endproperty
    a_one_busy: assert property (p_one_busy) else $error("accepted while busy");

    property p_fill_unpinned;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_fill |-> !r_pin[w_lru];
    endproperty
    a_fill_unpinned: assert property (p_fill_unpinned) else $error("pinned victim");

    property p_wb_dirty;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid && o_writeback_needed |-> o_status == ST_MISS;
    endproperty
    a_wb_dirty: assert property (p_wb_dirty) else $error("writeback without miss");
endmodule

FILE: rtl/lbpc_order.sv
// Recency list: one-step shift of a chosen slot to the MRU end.
module lbpc_order (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_move,
    input  lbpc_pkg::t_slot     i_slot,
    output lbpc_pkg::t_slot     o_lru
);
    import lbpc_pkg::*;

    t_slot r_order [SLOTS];
    logic [SLOTS-1:0] w_after;

    // w_after[p]: target slot sits at or before p
    always_comb begin
        w_after[0] = (r_order[0] == i_slot);
        for (int p = 1; p < SLOTS; p++) begin
            w_after[p] = w_after[p-1] | (r_order[p] == i_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < SLOTS; p++) begin
                r_order[p] <= t_slot'(p);
            end
        end else if (i_move && w_after[SLOTS-1]) begin
            for (int p = 0; p < SLOTS - 1; p++) begin
                if (w_after[p]) begin
                    r_order[p] <= r_order[p+1];
                end
            end
            r_order[SLOTS-1] <= i_slot;
        end
    end

    assign o_lru = r_order[0];

    property p_mru_after_move;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_move |=> r_order[SLOTS-1] == $past(i_slot);
    endproperty
    a_mru_after_move: assert property (p_mru_after_move) else $error("mru not updated");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            !i_move |=> $stable(r_order[0]);
    endproperty
    a_hold: assert property (p_hold) else $error("order changed without move");

    property p_lru_differs;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_order[0] != r_order[SLOTS-1];
    endproperty
    a_lru_differs: assert property (p_lru_differs) else $error("order not a permutation");
endmodule

FILE: test/lru_buffer_pool_controller_test.sv
// Testbench for the LRU buffer pool controller: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module lru_buffer_pool_controller_test;
    import lbpc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_opcode;
    logic [7:0]  i_file_id;
    logic [31:0] i_byte_address;
    logic [3:0]  i_slot_select;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [3:0]  o_slot;
    logic [11:0] o_block_offset;
    logic [19:0] o_fetch_tag;
    logic        o_writeback_needed;
    logic [7:0]  o_writeback_file;
    logic [19:0] o_writeback_tag;

    lru_buffer_pool_controller dut (.*);

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [11:0] offset;
        logic [19:0] fetch_tag;
        logic        wb_needed;
        logic [7:0]  wb_file;
        logic [19:0] wb_tag;
    } t_outcome;

    logic        pool_valid [SLOTS];
    logic [7:0]  pool_file [SLOTS];
    logic [19:0] pool_tag [SLOTS];
    logic        pool_dirty [SLOTS];
    logic        pool_pinned [SLOTS];
    int          recency [SLOTS];

    t_outcome outcome_q[$];
    int       error_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_cycles = 0;

    initial begin
        i_clk = 0;
    end
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic void promote(int s);
        int p;
        p = 0;
        while (p < SLOTS && recency[p] != s) p++;
        for (int i = p; i + 1 < SLOTS; i++) recency[i] = recency[i + 1];
        recency[SLOTS - 1] = s;
    endfunction

    task automatic pool_clear();
        for (int i = 0; i < SLOTS; i++) begin
            pool_valid[i] = 0;
            pool_file[i] = 0;
            pool_tag[i] = 0;
            pool_dirty[i] = 0;
            pool_pinned[i] = 0;
            recency[i] = i;
        end
    endtask

    function automatic void apply_request(input t_opcode op, input logic [7:0] fid,
                                          input logic [31:0] addr, input logic [3:0] sel,
                                          output t_outcome r);
        logic [19:0] tag;
        int s, v, tries;
        r = '0;
        r.status = ST_MAINT;
        if (op == OP_READ || op == OP_WRITE) begin
            tag = addr[31:12];
            s = -1;
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && pool_valid[i] && pool_file[i] == fid && pool_tag[i] == tag) s = i;
            if (s >= 0) begin
                promote(s);
                r.status = ST_HIT;
            end else begin
                tries = 0;
                v = recency[0];
                while (tries < SLOTS && pool_pinned[v]) begin
                    promote(v);
                    v = recency[0];
                    tries++;
                end
                if (tries >= SLOTS) begin
                    r.status = ST_PINNED;
                    return;
                end
                if (pool_valid[v] && pool_dirty[v]) begin
                    r.wb_needed = 1;
                    r.wb_file = pool_file[v];
                    r.wb_tag = pool_tag[v];
                end
                promote(v);
                pool_valid[v] = 1;
                pool_dirty[v] = 0;
                pool_file[v] = fid;
                pool_tag[v] = tag;
                r.status = ST_MISS;
                r.fetch_tag = tag;
                s = v;
            end
            if (op == OP_WRITE) pool_dirty[s] = 1;
            r.slot = 4'(s);
            r.offset = addr[11:0];
        end else if (op == OP_PIN || op == OP_UNPIN) begin
            pool_pinned[sel] = (op == OP_PIN);
            r.slot = sel;
        end else if (op == OP_INVAL) begin
            for (int i = 0; i < SLOTS; i++)
                if (pool_valid[i] && pool_file[i] == fid) begin
                    pool_valid[i] = 0;
                    pool_dirty[i] = 0;
                    pool_pinned[i] = 0;
                    pool_file[i] = 0;
                    pool_tag[i] = 0;
                end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_request(t_opcode op, logic [7:0] fid, logic [31:0] addr,
                                logic [3:0] sel);
        t_outcome r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_opcode <= op;
        i_file_id <= fid;
        i_byte_address <= addr;
        i_slot_select <= sel;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_request(op, fid, addr, sel, r);
        outcome_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 0;
        end else begin
            i_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid && i_ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected result", o_status, 0);
            end else begin
                e = outcome_q.pop_front();
                if (o_status != e.status) report_mismatch("status", o_status, e.status);
                if (o_slot != e.slot) report_mismatch("slot", o_slot, e.slot);
                if (o_block_offset != e.offset)
                    report_mismatch("block_offset", o_block_offset, e.offset);
                if (o_fetch_tag != e.fetch_tag)
                    report_mismatch("fetch_tag", o_fetch_tag, e.fetch_tag);
                if (o_writeback_needed != e.wb_needed)
                    report_mismatch("writeback_needed", o_writeback_needed, e.wb_needed);
                if (o_writeback_file != e.wb_file)
                    report_mismatch("writeback_file", o_writeback_file, e.wb_file);
                if (o_writeback_tag != e.wb_tag)
                    report_mismatch("writeback_tag", o_writeback_tag, e.wb_tag);
            end
        end
    end

    task automatic drain();
        i_valid <= 0;
        while (outcome_q.size() > 0) @(posedge i_clk);
    endtask

    // small working set so hits, evictions and write-backs all happen
    task automatic random_request();
        int k;
        logic [31:0] addr;
        k = $urandom_range(99);
        addr = {12'($urandom_range(0, 23)), 8'd0, 12'($urandom)};
        if ($urandom_range(9) == 0) addr = $urandom;
        if (k < 40) send_request(OP_READ, 8'($urandom_range(0, 3)), addr, 4'($urandom));
        else if (k < 75) send_request(OP_WRITE, 8'($urandom_range(0, 3)), addr, 4'($urandom));
        else if (k < 85) send_request(OP_PIN, 8'($urandom), $urandom, 4'($urandom));
        else if (k < 95) send_request(OP_UNPIN, 8'($urandom), $urandom, 4'($urandom));
        else if (k < 98) send_request(OP_INVAL, 8'($urandom_range(0, 3)), $urandom,
                                      4'($urandom));
        else send_request(t_opcode'($urandom_range(5, 7)), 8'($urandom), $urandom,
                          4'($urandom));
    endtask

    task automatic test_directed();
        send_request(OP_READ, 8'h00, 32'h0000_0000, 4'h0);
        send_request(OP_WRITE, 8'hff, 32'hffff_ffff, 4'hf);
        send_request(OP_READ, 8'hff, 32'hffff_f000, 4'h0);
        send_request(OP_WRITE, 8'h00, 32'h0000_0fff, 4'h0);
        send_request(OP_READ, 8'h5a, 32'ha5a5_a5a5, 4'h5);
        send_request(OP_INVAL, 8'hff, 32'h0, 4'h0);
        send_request(OP_READ, 8'hff, 32'hffff_ffff, 4'h0);
        for (int i = 0; i < SLOTS; i++) send_request(OP_PIN, 8'h0, 32'h0, 4'(i));
        send_request(OP_READ, 8'h77, 32'h1234_5678, 4'h0);
        send_request(OP_UNPIN, 8'h0, 32'h0, 4'h9);
        send_request(OP_WRITE, 8'h77, 32'h1234_5678, 4'h0);
        send_request(3'd5, 8'h0, 32'h0, 4'h0);
        send_request(3'd7, 8'hff, 32'hffff_ffff, 4'hf);
        send_request(OP_INVAL, 8'h00, 32'h0, 4'h0);
        drain();
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            // unpin everything now and then so misses keep succeeding
            if ($urandom_range(29) == 0)
                for (int s = 0; s < SLOTS; s++) send_request(OP_UNPIN, 8'h0, 32'h0, 4'(s));
            random_request();
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        for (int i = 0; i < 10; i++) random_request();
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_opcode = OP_READ;
        i_file_id = 0;
        i_byte_address = 0;
        i_slot_select = 0;
        pool_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(145, 0, 0);
        test_random_phase(145, 53, 0);
        test_random_phase(145, 0, 53);
        test_random_phase(145, 38, 38);
        test_backpressure();
        repeat (60) @(posedge i_clk);
        if (error_count == 0) $display("PASS lru_buffer_pool_controller");
        else $display("FAIL lru_buffer_pool_controller");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL lru_buffer_pool_controller");
        $finish;
    end
endmodule
